@@ hdl/cl20_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cl20_pkg
// Shared types, op codes and constants for the Cl(2,0) multivector unit.
// ----------------------------------------------------------------------------
package cl20_pkg;

    localparam int FRAC_BITS = 16;

    typedef enum logic [2:0] {
        OP_GPROD   = 3'd0,
        OP_DOT     = 3'd1,
        OP_WEDGE   = 3'd2,
        OP_SANDWICH = 3'd3,
        OP_REVERSE = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] a_scalar;
        logic signed [31:0] a_e1;
        logic signed [31:0] a_e2;
        logic signed [31:0] a_e12;
        logic signed [31:0] b_scalar;
        logic signed [31:0] b_e1;
        logic signed [31:0] b_e2;
        logic signed [31:0] b_e12;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] r_scalar;
        logic signed [31:0] r_e1;
        logic signed [31:0] r_e2;
        logic signed [31:0] r_e12;
        logic               status;
    } out_item_t;

    typedef logic signed [31:0] mv_t [4];

    // Products are rounded, then shifted. Result fits in 64 bits.
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    function automatic logic signed [63:0] round_prod(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = (p >= 0) ? p + HALF : p - HALF;
        return q >>> FRAC_BITS;
    endfunction

    function automatic logic fits32(input logic signed [63:0] v);
        return (v >= -64'sd2147483648) && (v <= 64'sd2147483647);
    endfunction

endpackage

@@ hdl/cl20_gp_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cl20_gp_stage
// Pipelined geometric product: multiply stage, round/check stage, sum stage.
// A stall freezes every register.
// ----------------------------------------------------------------------------
module cl20_gp_stage (
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  a [4],
    input  logic signed [31:0]  b [4],
    input  logic                ovf_in,
    output logic signed [31:0]  r [4],
    output logic                ovf
);

    logic signed [63:0] prod_reg [4][4];
    logic               ovf1_reg;
    logic signed [33:0] rp_reg [4][4];
    logic               ovf2_reg;
    logic signed [31:0] r_reg [4];
    logic               ovf3_reg;

    logic signed [33:0] rp_next [4][4];
    logic               ovf2_next;
    logic signed [35:0] s [4];
    logic               ovf3_next;
    logic signed [63:0] t;

    always_comb
    begin
        ovf2_next = ovf1_reg;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                t = cl20_pkg::round_prod(prod_reg[i][j]);
                rp_next[i][j] = t[33:0];
                if (!cl20_pkg::fits32(t))
                    ovf2_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        s[0] = 36'(rp_reg[0][0]) + 36'(rp_reg[1][1]) + 36'(rp_reg[2][2]) - 36'(rp_reg[3][3]);
        s[1] = 36'(rp_reg[0][1]) + 36'(rp_reg[1][0]) - 36'(rp_reg[2][3]) + 36'(rp_reg[3][2]);
        s[2] = 36'(rp_reg[0][2]) + 36'(rp_reg[2][0]) + 36'(rp_reg[1][3]) - 36'(rp_reg[3][1]);
        s[3] = 36'(rp_reg[0][3]) + 36'(rp_reg[3][0]) + 36'(rp_reg[1][2]) - 36'(rp_reg[2][1]);
        ovf3_next = ovf2_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (s[i] < -36'sd2147483648 || s[i] > 36'sd2147483647)
                ovf3_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[i][j] <= 64'(a[i]) * 64'(b[j]);
                    rp_reg[i][j]   <= rp_next[i][j];
                end
                r_reg[i] <= s[i][31:0];
            end
            ovf1_reg <= ovf_in;
            ovf2_reg <= ovf2_next;
            ovf3_reg <= ovf3_next;
        end
    end

    assign r   = r_reg;
    assign ovf = ovf3_reg;

endmodule

@@ hdl/cl20_multivector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cl20_multivector_unit
// Fixed-point Cl(2,0) multivector arithmetic: geometric product, dot,
// wedge, rotor sandwich and reverse.
// ----------------------------------------------------------------------------
// Usage: drive in_item with in_valid; a transaction is accepted when in_valid
// is high and in_stall is low. Results leave on out_item with out_valid and
// are taken when out_stall is low.
// The pipeline holds eight stages: two geometric product units of three
// stages each, with the second product's operands registered in between, and
// a final output stage. Dot, wedge and reverse run in a three-stage side path
// (multiply, round, sum) and are carried alongside the products.
// out_valid rises when a result reaches the final output stage, for every op.
// One transaction is accepted per cycle while in_stall is low.
// When out_stall is high with a valid result waiting, the whole pipeline
// freezes and in_stall is raised; nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module cl20_multivector_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cl20_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cl20_pkg::out_item_t  out_item
);

    localparam int DEPTH = 8;

    logic en;
    logic [DEPTH-1:0] vld_reg;
    logic [2:0]       op_reg [DEPTH-1];
    logic signed [31:0] a_reg [4][4];
    logic signed [31:0] side_reg [2:DEPTH-2][4];
    logic             sovf_reg [2:DEPTH-2];

    logic signed [31:0] a_in [4];
    logic signed [31:0] b_in [4];
    logic signed [31:0] g1 [4];
    logic               g1_ovf;
    logic signed [31:0] ra [4];
    logic signed [31:0] t_reg [4];
    logic               t_ovf_reg;
    logic signed [31:0] g2 [4];
    logic               g2_ovf;
    logic signed [31:0] gp_d [4][4];
    logic               gp_ovf_d [4];
    logic signed [63:0] x, y;
    logic signed [63:0] x_reg, y_reg;
    logic signed [63:0] xr, yr;
    logic signed [33:0] xr_reg, yr_reg;
    logic               xy_ovf_reg;
    logic signed [33:0] dw;
    logic signed [31:0] side_in [4];
    logic               side_ovf;
    cl20_pkg::out_item_t out_reg;
    cl20_pkg::out_item_t out_next;

    assign en       = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !en;

    assign a_in = '{in_item.a_scalar, in_item.a_e1, in_item.a_e2, in_item.a_e12};
    assign b_in = '{in_item.b_scalar, in_item.b_e1, in_item.b_e2, in_item.b_e12};

    // Dot and wedge share two multipliers; the operand pairing follows the op.
    always_comb
    begin
        if (in_item.op == cl20_pkg::OP_WEDGE)
        begin
            x = 64'(in_item.a_e1) * 64'(in_item.b_e2);
            y = 64'(in_item.a_e2) * 64'(in_item.b_e1);
        end
        else
        begin
            x = 64'(in_item.a_e1) * 64'(in_item.b_e1);
            y = 64'(in_item.a_e2) * 64'(in_item.b_e2);
        end
    end

    assign xr = cl20_pkg::round_prod(x_reg);
    assign yr = cl20_pkg::round_prod(y_reg);

    // Dot, wedge and reverse results enter the side pipe at stage 2.
    always_comb
    begin
        side_in  = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
        side_ovf = 1'b0;
        dw = (op_reg[1] == cl20_pkg::OP_WEDGE) ? xr_reg - yr_reg : xr_reg + yr_reg;
        case (op_reg[1])
            cl20_pkg::OP_DOT, cl20_pkg::OP_WEDGE:
            begin
                side_ovf = xy_ovf_reg || dw < -34'sd2147483648 || dw > 34'sd2147483647;
                if (op_reg[1] == cl20_pkg::OP_DOT)
                    side_in[0] = dw[31:0];
                else
                    side_in[3] = dw[31:0];
            end
            cl20_pkg::OP_REVERSE:
                side_in = '{a_reg[1][0], a_reg[1][1], a_reg[1][2], -a_reg[1][3]};
            default:
                side_in = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
        endcase
    end

    cl20_gp_stage u_gp1 (
        .clk(clk), .en(en), .a(a_in), .b(b_in), .ovf_in(1'b0),
        .r(g1), .ovf(g1_ovf)
    );

    // reverse(a) taken from the delayed copy of a.
    assign ra = '{a_reg[2][0], a_reg[2][1], a_reg[2][2], -a_reg[2][3]};

    cl20_gp_stage u_gp2 (
        .clk(clk), .en(en), .a(t_reg), .b(a_reg[3]), .ovf_in(t_ovf_reg),
        .r(g2), .ovf(g2_ovf)
    );

    always_comb
    begin
        out_next = '0;
        case (op_reg[DEPTH-2])
            cl20_pkg::OP_GPROD:
            begin
                if (gp_ovf_d[3])
                    out_next.status = 1'b1;
                else
                begin
                    out_next.r_scalar = gp_d[3][0];
                    out_next.r_e1     = gp_d[3][1];
                    out_next.r_e2     = gp_d[3][2];
                    out_next.r_e12    = gp_d[3][3];
                end
            end
            cl20_pkg::OP_SANDWICH:
            begin
                if (g2_ovf)
                    out_next.status = 1'b1;
                else
                begin
                    out_next.r_scalar = g2[0];
                    out_next.r_e1     = g2[1];
                    out_next.r_e2     = g2[2];
                    out_next.r_e12    = g2[3];
                end
            end
            cl20_pkg::OP_DOT, cl20_pkg::OP_WEDGE, cl20_pkg::OP_REVERSE:
            begin
                if (sovf_reg[DEPTH-2])
                    out_next.status = 1'b1;
                else
                begin
                    out_next.r_scalar = side_reg[DEPTH-2][0];
                    out_next.r_e1     = side_reg[DEPTH-2][1];
                    out_next.r_e2     = side_reg[DEPTH-2][2];
                    out_next.r_e12    = side_reg[DEPTH-2][3];
                end
            end
            default:
                out_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0] <= in_item.op;
            for (int k = 1; k < DEPTH-1; k++)
                op_reg[k] <= op_reg[k-1];
            x_reg      <= x;
            y_reg      <= y;
            xr_reg     <= xr[33:0];
            yr_reg     <= yr[33:0];
            xy_ovf_reg <= !cl20_pkg::fits32(xr) || !cl20_pkg::fits32(yr);
            side_reg[2] <= side_in;
            sovf_reg[2] <= side_ovf;
            for (int k = 3; k < DEPTH-1; k++)
            begin
                side_reg[k] <= side_reg[k-1];
                sovf_reg[k] <= sovf_reg[k-1];
            end
            a_reg[0] <= a_in;
            a_reg[1] <= a_reg[0];
            a_reg[2] <= a_reg[1];
            a_reg[3] <= ra;
            t_reg     <= g1;
            t_ovf_reg <= g1_ovf;
            // Geometric product results wait for the second unit to finish.
            gp_d[0]     <= g1;
            gp_ovf_d[0] <= g1_ovf;
            for (int k = 1; k < 4; k++)
            begin
                gp_d[k]     <= gp_d[k-1];
                gp_ovf_d[k] <= gp_ovf_d[k-1];
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_item  = out_reg;

endmodule
